/* design/ffsa_pkg.sv */
// ffsa_pkg: shared types, constants and codes of the spectrum allocator.
// No dependencies.
`default_nettype none
package ffsa_pkg;
  localparam int NUM_LINKS_DEF = 64;
  localparam int NUM_SLOTS_DEF = 256;
  localparam int MAX_ROUTE_DEF = 16;
  localparam logic [19:0] DIST_MAX = 20'hFFFFF;
  localparam logic [19:0] SHORT_RST = 20'd200;
  localparam logic [19:0] MEDIUM_RST = 20'd1600;
  localparam logic [5:0] SPC_RST = 6'd9;
  localparam logic [16:0] CAP_32QAM = 17'd800;
  localparam logic [16:0] CAP_16QAM = 17'd600;
  localparam logic [16:0] CAP_8QAM = 17'd400;
  localparam logic [15:0] RATE_STEP = 16'd400;
  // floor(x * 2622 / 2^16) == floor(x / 25) for x < 4681
  localparam logic [23:0] RATE_RECIP = 24'd2622;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0, CMD_ALLOC = 2'd1, CMD_RELEASE = 2'd2, CMD_CLEAR = 2'd3
  } cmd_t;
  typedef enum logic [2:0] {
    ST_DONE = 3'd0, ST_ALLOC = 3'd1, ST_NOFIT = 3'd2, ST_ROUTE = 3'd3, ST_RANGE = 3'd4
  } status_t;
  typedef enum logic [1:0] {
    MOD_8QAM = 2'd0, MOD_16QAM = 2'd1, MOD_32QAM = 2'd2
  } mod_t;
  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_MEDIUM = 2'd1;
  localparam logic [1:0] REG_SPC = 2'd2;

  typedef struct packed {
    logic       clr_route;
    logic       clr_result;
    logic       add_edge;
    logic       start_div;
    logic       setup_alloc;
    logic       setup_rel;
    logic       clr_acc;
    logic       rd_issue;
    logic       acc_and;
    logic       wr_issue;
    logic       next_cand;
    logic       found_set;
  } ffsa_cmd_t;

  typedef struct packed {
    logic       route_empty;
    logic       route_full;
    logic       div_done;
    logic       too_wide;
    logic       last_link;
    logic       cand_free;
    logic       cand_last;
    logic       rel_bad;
    logic       rel_zero;
  } ffsa_stat_t;
endpackage
`default_nettype wire

/* design/ffsa_if.sv */
// ffsa request channel interfaces: valid/ready with payload.
// Depends on nothing.
`default_nettype none
interface ffsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  edge_index;
  logic [15:0] edge_length;
  logic [15:0] demand_rate;
  logic [7:0]  release_start;
  logic [8:0]  release_width;
  modport source(output valid, command, edge_index, edge_length, demand_rate,
                 release_start, release_width, input ready);
  modport sink(input valid, command, edge_index, edge_length, demand_rate,
               release_start, release_width, output ready);
endinterface

interface ffsa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  first_slot;
  logic [12:0] window_width;
  logic [1:0]  modulation;
  logic [7:0]  carrier_count;
  logic [16:0] capacity_gbps;
  modport source(output valid, status, first_slot, window_width, modulation,
                 carrier_count, capacity_gbps, input ready);
  modport sink(input valid, status, first_slot, window_width, modulation,
               carrier_count, capacity_gbps, output ready);
endinterface

interface ffsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/ffsa_ram.sv */
// ffsa_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/ffsa_datapath.sv */
// ffsa_datapath: route registers, link bitmap memory, window search and mark.
// Depends on ffsa_pkg and ffsa_ram.
`default_nettype none
module ffsa_datapath #(
  parameter int NUM_LINKS = ffsa_pkg::NUM_LINKS_DEF,
  parameter int NUM_SLOTS = ffsa_pkg::NUM_SLOTS_DEF,
  parameter int MAX_ROUTE = ffsa_pkg::MAX_ROUTE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ffsa_pkg::ffsa_cmd_t cmd,
  output ffsa_pkg::ffsa_stat_t    stat,
  input  wire logic [5:0]         edge_index,
  input  wire logic [15:0]        edge_length,
  input  wire logic [15:0]        demand_rate,
  input  wire logic [7:0]         release_start,
  input  wire logic [8:0]         release_width,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  output logic [7:0]              first_slot,
  output logic [12:0]             window_width,
  output logic [1:0]              modulation,
  output logic [7:0]              carrier_count,
  output logic [16:0]             capacity_gbps
);
  localparam int LW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int RW = (MAX_ROUTE > 1) ? $clog2(MAX_ROUTE) : 1;
  localparam int CW = $clog2(MAX_ROUTE + 1);
  localparam int SW = $clog2(NUM_SLOTS + 1);

  logic [19:0] short_limit, medium_limit;
  logic [5:0]  spc;
  logic [LW-1:0] route [MAX_ROUTE];
  logic [CW-1:0] route_count;
  logic [19:0] distance;
  logic [CW-1:0] link_ptr;
  logic [NUM_SLOTS-1:0] occ_acc, win_mask, rd_word;
  logic [SW-1:0] cand, win_w;
  logic          mark_val;
  logic [7:0]    carriers;
  logic [23:0]   quot_prod;
  logic [7:0]    div_q;
  logic          rate_big;
  logic          div_busy;
  logic [12:0]   width_full;
  logic [5:0]    spc_eff;
  logic [20:0]   dist_sum;
  logic          ram_we;
  logic [LW-1:0] ram_addr;
  logic [NUM_SLOTS-1:0] ram_wdata;
  logic [NUM_SLOTS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit <= ffsa_pkg::SHORT_RST;
      medium_limit <= ffsa_pkg::MEDIUM_RST;
      spc <= ffsa_pkg::SPC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffsa_pkg::REG_SHORT: short_limit <= cfg_data;
        ffsa_pkg::REG_MEDIUM: medium_limit <= cfg_data;
        ffsa_pkg::REG_SPC: spc <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign dist_sum = {1'b0, distance} + {5'd0, edge_length};
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_route) begin
      route_count <= '0;
      distance <= '0;
    end else if (cmd.add_edge) begin
      route_count <= route_count + 1'b1;
      distance <= dist_sum[20] ? ffsa_pkg::DIST_MAX : dist_sum[19:0];
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.add_edge) route[route_count[RW-1:0]] <= LW'(edge_index % NUM_LINKS);
  end

  // carriers for 8-QAM: rate/400 as (rate>>4)/25 by reciprocal multiply
  assign quot_prod = 24'(demand_rate[15:4]) * ffsa_pkg::RATE_RECIP;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.start_div) begin
      div_busy <= 1'b1;
      div_q <= quot_prod[23:16];
      rate_big <= demand_rate > ffsa_pkg::RATE_STEP;
    end else begin
      div_busy <= 1'b0;
    end
  end
  assign stat.div_done = div_busy;

  assign spc_eff = (spc == 6'd0) ? 6'd1 : (spc > 6'd32) ? 6'd32 : spc;
  always_comb begin
    carriers = 8'd1;
    if (distance > short_limit && distance > medium_limit && rate_big) carriers = div_q + 8'd1;
  end
  assign width_full = 13'(carriers) * 13'(spc_eff);

  always_ff @(posedge clk) begin
    if (cmd.setup_alloc) begin
      window_width <= width_full;
      carrier_count <= carriers;
      if (distance <= short_limit) begin
        modulation <= ffsa_pkg::MOD_32QAM;
        capacity_gbps <= ffsa_pkg::CAP_32QAM;
      end else if (distance <= medium_limit) begin
        modulation <= ffsa_pkg::MOD_16QAM;
        capacity_gbps <= ffsa_pkg::CAP_16QAM;
      end else begin
        modulation <= ffsa_pkg::MOD_8QAM;
        capacity_gbps <= 17'(carriers * ffsa_pkg::CAP_8QAM);
      end
      win_w <= (width_full > 13'(NUM_SLOTS)) ? SW'(NUM_SLOTS) : SW'(width_full);
      cand <= '0;
      first_slot <= '0;
      mark_val <= 1'b1;
    end else if (cmd.setup_rel) begin
      window_width <= '0;
      carrier_count <= '0;
      modulation <= ffsa_pkg::MOD_8QAM;
      capacity_gbps <= '0;
      first_slot <= '0;
      cand <= SW'(release_start);
      win_w <= SW'(release_width);
      mark_val <= 1'b0;
    end else begin
      if (cmd.next_cand) cand <= cand + 1'b1;
      if (cmd.found_set) first_slot <= 8'(cand);
      if (cmd.clr_result) begin
        window_width <= '0;
        carrier_count <= '0;
        modulation <= ffsa_pkg::MOD_8QAM;
        capacity_gbps <= '0;
        first_slot <= '0;
      end
    end
  end
  assign stat.too_wide = window_width > 13'(NUM_SLOTS);
  assign stat.rel_bad = ({2'b0, release_start} + {1'b0, release_width}) > 10'(NUM_SLOTS);
  assign stat.rel_zero = release_width == 9'd0;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) win_mask[i] = (i >= cand) && (i < cand + win_w);
  end

  // link pointer walks the route, advanced by reads only
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      link_ptr <= '0;
      occ_acc <= '0;
    end else begin
      if (cmd.acc_and) occ_acc <= occ_acc | rd_word;
      if (cmd.rd_issue) link_ptr <= link_ptr + 1'b1;
    end
  end
  assign stat.last_link = link_ptr >= route_count;
  assign stat.cand_free = (occ_acc & win_mask) == '0;
  assign stat.cand_last = (cand + win_w) >= SW'(NUM_SLOTS);
  assign stat.route_empty = route_count == '0;
  assign stat.route_full = route_count >= CW'(MAX_ROUTE);

  // write needs the old word: rd then wr on same link; wr_issue carries link_ptr-1
  logic [LW-1:0] wr_link;
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) wr_link <= route[link_ptr[RW-1:0]];
  end
  logic [NUM_SLOTS-1:0] rst_valid;
  logic [NUM_LINKS-1:0] link_valid;
  logic [LW-1:0] rd_link_q;
  always_ff @(posedge clk) begin
    if (rst) link_valid <= '0;
    else if (ram_we) link_valid[ram_addr] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_link_q <= route[link_ptr[RW-1:0]];
  end
  assign ram_we = cmd.wr_issue;
  assign ram_addr = cmd.wr_issue ? wr_link : route[link_ptr[RW-1:0]];
  assign rst_valid = link_valid[rd_link_q] ? ram_rdata : '0;
  assign rd_word = rst_valid;
  assign ram_wdata = mark_val ? (rd_word | win_mask) : (rd_word & ~win_mask);

  ffsa_ram #(.WIDTH(NUM_SLOTS), .DEPTH(NUM_LINKS)) u_bitmap (
    .clk(clk), .we(ram_we), .waddr(wr_link), .wdata(ram_wdata),
    .raddr(ram_addr), .rdata(ram_rdata)
  );
endmodule
`default_nettype wire

/* design/ffsa_ctrl.sv */
// ffsa_ctrl: sequencer for add, allocate, release and clear requests.
// Depends on ffsa_pkg.
`default_nettype none
module ffsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output ffsa_pkg::ffsa_cmd_t      cmd,
  input  wire ffsa_pkg::ffsa_stat_t stat
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DIV = 9'b000000010, S_SETUP = 9'b000000100,
    S_SRD = 9'b000001000, S_SWAIT = 9'b000010000, S_CHECK = 9'b000100000,
    S_MRD = 9'b001000000, S_MWR = 9'b010000000, S_OUT = 9'b100000000
  } state_t;
  state_t state, state_next;
  logic [2:0] status_next;

  always_comb begin
    state_next = state;
    status_next = status;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_next = ffsa_pkg::ST_DONE;
          cmd.clr_result = 1'b1;
          unique case (command)
            ffsa_pkg::CMD_ADD: begin
              if (stat.route_full) status_next = ffsa_pkg::ST_ROUTE;
              else cmd.add_edge = 1'b1;
              state_next = S_OUT;
            end
            ffsa_pkg::CMD_ALLOC: begin
              cmd.clr_route = 1'b0;
              if (stat.route_empty) begin
                status_next = ffsa_pkg::ST_ROUTE;
                state_next = S_OUT;
              end else begin
                cmd.start_div = 1'b1;
                state_next = S_DIV;
              end
            end
            ffsa_pkg::CMD_RELEASE: begin
              cmd.setup_rel = 1'b1;
              cmd.clr_acc = 1'b1;
              if (stat.route_empty) begin
                status_next = ffsa_pkg::ST_ROUTE;
                state_next = S_OUT;
              end else if (stat.rel_bad) begin
                status_next = ffsa_pkg::ST_RANGE;
                state_next = S_OUT;
              end else if (stat.rel_zero) state_next = S_OUT;
              else state_next = S_MRD;
            end
            default: begin
              cmd.clr_route = 1'b1;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_DIV: if (stat.div_done) begin
        cmd.setup_alloc = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.clr_acc = 1'b1;
        if (stat.too_wide) begin
          status_next = ffsa_pkg::ST_NOFIT;
          state_next = S_OUT;
        end else state_next = S_SRD;
      end
      S_SRD: begin
        cmd.rd_issue = 1'b1;
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        cmd.acc_and = 1'b1;
        state_next = stat.last_link ? S_CHECK : S_SRD;
      end
      S_CHECK: begin
        if (stat.cand_free) begin
          cmd.found_set = 1'b1;
          cmd.clr_acc = 1'b1;
          status_next = ffsa_pkg::ST_ALLOC;
          state_next = S_MRD;
        end else if (stat.cand_last) begin
          status_next = ffsa_pkg::ST_NOFIT;
          state_next = S_OUT;
        end else begin
          cmd.next_cand = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_MRD: begin
        cmd.rd_issue = 1'b1;
        state_next = S_MWR;
      end
      S_MWR: begin
        cmd.wr_issue = 1'b1;
        cmd.acc_and = 1'b0;
        state_next = stat.last_link ? S_OUT : S_MRD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // link pointer advances on reads only; the write reuses the link just read
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= ffsa_pkg::ST_DONE;
    end else begin
      state <= state_next;
      status <= status_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state));
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("overlap");
endmodule
`default_nettype wire

/* design/first_fit_spectrum_allocator_unit.sv */
// First-fit spectrum allocator top level: controller plus datapath.
// Add, clear, rejected and zero-width requests go straight to the result; release reads and
// rewrites each link; allocate scans each route link, tries start slots in order (up to 256)
// and marks each link on success, paced by the single bitmap read port; too wide skips the
// scan. One request at a time, held until taken. Sync reset: bitmaps free, route empty.
// Depends on ffsa_pkg, ffsa_if, ffsa_ram, ffsa_datapath, ffsa_ctrl.
`default_nettype none
module first_fit_spectrum_allocator_unit #(
  parameter int NUM_LINKS = ffsa_pkg::NUM_LINKS_DEF,
  parameter int NUM_SLOTS = ffsa_pkg::NUM_SLOTS_DEF,
  parameter int MAX_ROUTE_LINKS = ffsa_pkg::MAX_ROUTE_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ffsa_in_if.sink  req,
  ffsa_out_if.source rsp,
  ffsa_cfg_if.sink cfg
);
  ffsa_pkg::ffsa_cmd_t  cmd;
  ffsa_pkg::ffsa_stat_t stat;
  logic busy_n;

  assign cfg.ready = 1'b1;
  ffsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(busy_n),
    .command(req.command), .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status(rsp.status), .cmd(cmd), .stat(stat)
  );
  assign req.ready = busy_n;
  ffsa_datapath #(.NUM_LINKS(NUM_LINKS), .NUM_SLOTS(NUM_SLOTS),
                  .MAX_ROUTE(MAX_ROUTE_LINKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .edge_index(req.edge_index), .edge_length(req.edge_length),
    .demand_rate(req.demand_rate), .release_start(req.release_start),
    .release_width(req.release_width),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .first_slot(rsp.first_slot), .window_width(rsp.window_width),
    .modulation(rsp.modulation), .carrier_count(rsp.carrier_count),
    .capacity_gbps(rsp.capacity_gbps)
  );
endmodule
`default_nettype wire
